>>> hw/rtl/ggc_pkg.sv
// Shared constants, types and helpers for the greedy graph coloring block.
package ggc_pkg;

  localparam int unsigned ID_W            = 12;   // vertex id field width
  localparam int unsigned COLOUR_OUT_W    = 8;    // color fields on the result
  localparam int unsigned DEF_VERTICES    = 4096;
  localparam int unsigned DEF_MAX_COLOURS = 256;

  // The free-color search looks at the mask in groups of this many colors.
  localparam int unsigned GROUP_W  = 16;
  localparam int unsigned GROUP_IW = $clog2(GROUP_W);

  // Identifies the vertex whose color an end-of-run item will write.
  typedef struct packed {
    logic [ID_W-1:0] vid;
    logic            ok;   // vid is inside the table
  } ggc_tag_t;

  // Lowest clear bit of a group; all-ones groups are flagged separately.
  function automatic logic [GROUP_IW-1:0] ggc_first_zero(input logic [GROUP_W-1:0] bits);
    logic [GROUP_IW-1:0] idx;
    idx = '0;
    for (int i = GROUP_W - 1; i >= 0; i--) begin
      if (!bits[i]) idx = GROUP_IW'(i);
    end
    return idx;
  endfunction

endpackage

>>> hw/rtl/ggc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module ggc_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read and a write to one address in the same cycle return old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ggc_pick.sv
// Two-step search for the lowest free color in a used-color mask.
module ggc_pick #(
  parameter int unsigned MAX_COLOURS = ggc_pkg::DEF_MAX_COLOURS,
  localparam int unsigned CI         = (MAX_COLOURS > 1) ? $clog2(MAX_COLOURS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [MAX_COLOURS-1:0] in_mask_i,
  input  ggc_pkg::ggc_tag_t      in_tag_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CI-1:0]          out_pick_o,
  output logic                   out_full_o,
  output ggc_pkg::ggc_tag_t      out_tag_o
);

  import ggc_pkg::*;

  localparam int unsigned NG  = (MAX_COLOURS + GROUP_W - 1) / GROUP_W;
  localparam int unsigned NGW = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned PAD = NG * GROUP_W;

  logic [PAD-1:0]      padded;
  logic                valid_q;
  ggc_tag_t            tag_q;
  logic [NG-1:0]       free_q, free_d;
  logic [GROUP_IW-1:0] idx_q [NG];
  logic [GROUP_IW-1:0] idx_d [NG];
  logic [NGW-1:0]      sel;
  logic                any_free;

  // Colors past the top are padded as used so they are never picked.
  always_comb begin
    padded                  = '1;
    padded[MAX_COLOURS-1:0] = in_mask_i;
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      free_d[g] = ~&padded[g*GROUP_W +: GROUP_W];
      idx_d[g]  = ggc_first_zero(padded[g*GROUP_W +: GROUP_W]);
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      free_q <= free_d;
      idx_q  <= idx_d;
      tag_q  <= in_tag_i;
    end
  end

  // Lowest group with a free color.
  always_comb begin
    sel      = '0;
    any_free = 1'b0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (free_q[g]) begin
        sel      = NGW'(g);
        any_free = 1'b1;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_full_o  = !any_free;
  assign out_pick_o  = any_free ? CI'({sel, idx_q[sel]}) : CI'(MAX_COLOURS - 1);
  assign out_tag_o   = tag_q;

endmodule

>>> hw/rtl/greedy_graph_colouring_top.sv
// Top level of the first-fit greedy graph coloring block.
//
//  channel  | dir | tdata                                 | tuser        | tlast
//  s_axis   | in  | [11:0] vertex_id, [23:12] neighbour_id| no_neighbour | last
//  m_axis   | out | [7:0] assigned_colour, [15:8] highest | overflow     | -
//
// One input transaction per cycle while s_axis_tready is high; an end item's result
// reaches m_axis through the neighbor, search and output registers. The color table
// RAM (one read, one write port) is read on every neighbor item. After reset a
// clearing sweep writes every table entry, with s_axis_tready low. A neighbor item
// naming a vertex whose color is still in flight waits for the table write.
// Output stalls back up through the search and neighbor stages only at end items.
module greedy_graph_colouring_top #(
  parameter int unsigned VERTICES    = ggc_pkg::DEF_VERTICES,
  parameter int unsigned MAX_COLOURS = ggc_pkg::DEF_MAX_COLOURS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [11:0] vertex_id, [23:12] neighbour_id
  input  logic        s_axis_tuser,   // no_neighbour
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] assigned_colour, [15:8] highest_colour
  output logic        m_axis_tuser    // overflow
);

  import ggc_pkg::*;

  localparam int unsigned AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_COLOURS + 1);
  localparam int unsigned CI = (MAX_COLOURS > 1) ? $clog2(MAX_COLOURS) : 1;

  // Clearing sweep
  logic          clr_q, clr_d;
  logic [AW-1:0] cnt_q, cnt_d;

  // Input decode
  logic [ID_W-1:0] in_vid, in_nid;
  logic            in_end, in_nbr_ok, in_fire, hazard;

  // Neighbor stage
  logic                   s1_valid_q, s1_nbr_q, s1_end_q;
  ggc_tag_t               s1_tag_q;
  logic                   s1_go, s1_ready, s1_hit;
  logic [MAX_COLOURS-1:0] mask_q, mask_d, mask_with;

  // Table RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [CW-1:0] ram_wdata, ram_rdata;

  // Search
  logic            pk_in_ready, pk_out_valid, pk_full;
  logic [CI-1:0]   pk_pick;
  ggc_tag_t        pk_tag;
  logic            res_fire;

  // Result
  logic                    out_valid_q;
  logic [CI-1:0]           highest_q, highest_d;
  logic [COLOUR_OUT_W-1:0] assigned_q, highest_out_q;
  logic                    overflow_q;

  assign in_vid    = s_axis_tdata[ID_W-1:0];
  assign in_nid    = s_axis_tdata[2*ID_W-1:ID_W];
  assign in_end    = s_axis_tlast || s_axis_tuser;
  assign in_nbr_ok = !s_axis_tuser && (32'(in_nid) < VERTICES);

  // A color still on its way to the table would be missed by the read.
  assign hazard = !s_axis_tuser &&
                  ((s1_valid_q && s1_end_q && s1_tag_q.ok && s1_tag_q.vid == in_nid) ||
                   (pk_out_valid && pk_tag.ok && pk_tag.vid == in_nid));

  assign s1_go         = s1_valid_q && (!s1_end_q || pk_in_ready);
  assign s1_ready      = !s1_valid_q || s1_go;
  assign s_axis_tready = !clr_q && s1_ready && !hazard;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    clr_d = clr_q;
    cnt_d = cnt_q;
    if (clr_q) begin
      cnt_d = cnt_q + AW'(1);
      if (cnt_q == AW'(VERTICES - 1)) clr_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      cnt_q <= '0;
    end else begin
      clr_q <= clr_d;
      cnt_q <= cnt_d;
    end
  end

  // Neighbor stage: fold the neighbor's color into the mask, cleared after end items.
  assign s1_hit = s1_nbr_q && (ram_rdata < CW'(MAX_COLOURS));

  always_comb begin
    for (int i = 0; i < MAX_COLOURS; i++) begin
      mask_with[i] = mask_q[i] || (s1_hit && ram_rdata[CI-1:0] == CI'(i));
    end
    mask_d = mask_q;
    if (s1_go) mask_d = s1_end_q ? '0 : mask_with;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      mask_q     <= '0;
    end else begin
      mask_q <= mask_d;
      if (s1_ready) s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_nbr_q     <= in_nbr_ok;
      s1_end_q     <= in_end;
      s1_tag_q.vid <= in_vid;
      s1_tag_q.ok  <= 32'(in_vid) < VERTICES;
    end
  end

  ggc_pick #(
    .MAX_COLOURS (MAX_COLOURS)
  ) u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q && s1_end_q),
    .in_ready_o  (pk_in_ready),
    .in_mask_i   (mask_with),
    .in_tag_i    (s1_tag_q),
    .out_valid_o (pk_out_valid),
    .out_ready_i (!out_valid_q || m_axis_tready),
    .out_pick_o  (pk_pick),
    .out_full_o  (pk_full),
    .out_tag_o   (pk_tag)
  );

  assign res_fire = pk_out_valid && (!out_valid_q || m_axis_tready);

  assign ram_we    = clr_q || (res_fire && pk_tag.ok);
  assign ram_waddr = clr_q ? cnt_q : AW'(pk_tag.vid);
  assign ram_wdata = clr_q ? CW'(MAX_COLOURS) : CW'(pk_pick);

  ggc_ram #(
    .WIDTH (CW),
    .DEPTH (VERTICES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (AW'(in_nid)),
    .rdata_o (ram_rdata)
  );

  assign highest_d = (pk_pick > highest_q) ? pk_pick : highest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      highest_q   <= '0;
    end else begin
      if (!out_valid_q || m_axis_tready) out_valid_q <= pk_out_valid;
      if (res_fire) highest_q <= highest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      assigned_q    <= COLOUR_OUT_W'(pk_pick);
      highest_out_q <= COLOUR_OUT_W'(highest_d);
      overflow_q    <= pk_full;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {highest_out_q, assigned_q};
  assign m_axis_tuser  = overflow_q;

  a_no_result_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire |-> !clr_q)
    else $error("color result during table clearing sweep");

  a_mask_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_end_q |=> mask_q == '0)
    else $error("used mask not cleared after end of run");

  a_highest_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_q |-> highest_q >= $past(highest_q))
    else $error("highest color decreased");

  a_overflow_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire && pk_full |-> pk_pick == CI'(MAX_COLOURS - 1))
    else $error("overflow without top color");

endmodule
